### hdl/wawm_pkg.sv
// Shared types and constants for the wrapped window angle mapper.
package wawm_pkg;

  localparam int READING_RANGE_DEF = 1024;
  localparam int RANGE_DIV         = 3;

  localparam int READING_W  = 10;
  localparam int MARK_W     = 10;
  localparam int SPAN_W     = 12;
  localparam int ANGLE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int ANGLE_MAX = 32767;
  localparam int ANGLE_MIN = -32768;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SPAN    = 2'd2;

  localparam logic [MARK_W-1:0] WINDOW_HIGH_RST = 10'd1023;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_ANGLE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic step;
    logic angle;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

### hdl/wawm_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module wawm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wawm_pkg::status_t status,
  output wawm_pkg::cmd_t    cmd
);

  wawm_pkg::state_t state_r;
  wawm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wawm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wawm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = wawm_pkg::ST_CALC;
        end
      end
      wawm_pkg::ST_CALC: begin
        state_nxt = status.bypass ? wawm_pkg::ST_FIN : wawm_pkg::ST_DIV;
      end
      wawm_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = wawm_pkg::ST_ANGLE;
        end
      end
      wawm_pkg::ST_ANGLE: begin
        state_nxt = wawm_pkg::ST_FIN;
      end
      wawm_pkg::ST_FIN: begin
        if (!status.out_busy) begin
          state_nxt = wawm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wawm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      wawm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      wawm_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
      end
      wawm_pkg::ST_DIV: begin
        cmd.step = 1'b1;
      end
      wawm_pkg::ST_ANGLE: begin
        cmd.angle = 1'b1;
      end
      wawm_pkg::ST_FIN: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### hdl/wawm_dp.sv
// Datapath: configuration registers, window arithmetic, serial divider and result register.
module wawm_dp #(
  parameter int READING_RANGE = wawm_pkg::READING_RANGE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [wawm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wawm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [wawm_pkg::READING_W-1:0]         in_reading,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [wawm_pkg::ANGLE_W-1:0]    out_angle,
  output logic signed [wawm_pkg::ANGLE_W-1:0]    out_change,
  output logic                                   out_window_empty,
  input  wawm_pkg::cmd_t                         cmd,
  output wawm_pkg::status_t                      status
);

  localparam int RW   = $clog2(READING_RANGE + 1);
  localparam int DW   = ((RW > wawm_pkg::READING_W) ? RW : wawm_pkg::READING_W) + 2;
  localparam int DENW = DW - 1;
  localparam int NW   = DW + wawm_pkg::SPAN_W;
  localparam int CW   = $clog2(NW);
  localparam int AW   = NW + 2;
  localparam int FW   = wawm_pkg::ANGLE_W + 2;
  localparam int NegLimInt = -(READING_RANGE / wawm_pkg::RANGE_DIV);

  localparam logic signed [DW-1:0] RANGE_S = DW'(READING_RANGE);
  localparam logic signed [DW-1:0] NEG_LIM = DW'(NegLimInt);
  localparam logic [CW-1:0]        LAST_CNT = CW'(NW - 1);
  localparam logic signed [AW-1:0] A_HI = AW'(wawm_pkg::ANGLE_MAX);
  localparam logic signed [AW-1:0] A_LO = AW'(wawm_pkg::ANGLE_MIN);
  localparam logic signed [FW-1:0] F_HI = FW'(wawm_pkg::ANGLE_MAX);
  localparam logic signed [FW-1:0] F_LO = FW'(wawm_pkg::ANGLE_MIN);

  logic [wawm_pkg::MARK_W-1:0]         lo_r;
  logic [wawm_pkg::MARK_W-1:0]         hi_r;
  logic signed [wawm_pkg::SPAN_W-1:0]  span_r;
  logic [wawm_pkg::READING_W-1:0]      rd_r;
  logic                                pass_r;
  logic                                empty_r;
  logic                                qneg_r;
  logic [DENW-1:0]                     den_r;
  logic [DENW-1:0]                     rem_r;
  logic [NW-1:0]                       q_r;
  logic [CW-1:0]                       cnt_r;
  logic signed [wawm_pkg::ANGLE_W-1:0] ang_r;
  logic signed [wawm_pkg::ANGLE_W-1:0] prev_r;
  logic signed [wawm_pkg::ANGLE_W-1:0] last_r;
  logic                                out_valid_r;
  logic signed [wawm_pkg::ANGLE_W-1:0] out_angle_r;
  logic signed [wawm_pkg::ANGLE_W-1:0] out_change_r;
  logic                                out_empty_r;

  logic                               pass;
  logic                               pos;
  logic [wawm_pkg::SPAN_W-1:0]        mag;
  logic signed [DW-1:0]               rd_s;
  logic signed [DW-1:0]               lo_s;
  logic signed [DW-1:0]               hi_s;
  logic signed [DW-1:0]               len_raw;
  logic signed [DW-1:0]               dist_raw;
  logic signed [DW-1:0]               len;
  logic signed [DW-1:0]               dist_adj;
  logic                               len_zero;
  logic [DENW-1:0]                    dist_mag;
  logic [DENW-1:0]                    len_mag;
  logic [NW-1:0]                      prod;
  logic [DENW:0]                      shifted;
  logic                               ge;
  logic [DENW:0]                      trial;
  logic signed [AW-1:0]               q_s;
  logic signed [AW-1:0]               ang_full;
  logic signed [wawm_pkg::ANGLE_W-1:0] ang_sat;
  logic signed [FW-1:0]               mag_f;
  logic signed [FW-1:0]               wrap_f;
  logic signed [FW-1:0]               d0;
  logic signed [FW-1:0]               d1;
  logic signed [FW-1:0]               d2;
  logic signed [wawm_pkg::ANGLE_W-1:0] chg_sat;

  always_comb begin
    pass = (span_r == '0);
    pos  = !span_r[wawm_pkg::SPAN_W-1] && !pass;
    mag  = span_r[wawm_pkg::SPAN_W-1] ? wawm_pkg::SPAN_W'(-span_r)
                                     : wawm_pkg::SPAN_W'(span_r);
    rd_s = $signed({{(DW - wawm_pkg::READING_W){1'b0}}, rd_r});
    lo_s = $signed({{(DW - wawm_pkg::MARK_W){1'b0}}, lo_r});
    hi_s = $signed({{(DW - wawm_pkg::MARK_W){1'b0}}, hi_r});
    if (pos) begin
      len_raw  = hi_s - lo_s;
      dist_raw = rd_s - lo_s;
      dist_adj = (dist_raw < 0) ? dist_raw + RANGE_S : dist_raw;
    end else begin
      len_raw  = lo_s - hi_s;
      dist_raw = lo_s - rd_s;
      dist_adj = (dist_raw < NEG_LIM) ? dist_raw + RANGE_S : dist_raw;
    end
    len      = (len_raw < 0) ? len_raw + RANGE_S : len_raw;
    len_zero = (len == '0);
    dist_mag = dist_adj[DW-1] ? DENW'(-dist_adj) : DENW'(dist_adj);
    len_mag  = len[DW-1] ? DENW'(-len) : DENW'(len);
    prod     = NW'(dist_mag) * NW'({mag, 1'b0});
  end

  always_comb begin
    shifted = {rem_r, q_r[NW-1]};
    ge      = (shifted >= {1'b0, den_r});
    trial   = shifted - {1'b0, den_r};
  end

  always_comb begin
    q_s      = qneg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
    ang_full = q_s - $signed(AW'(mag));
    if (ang_full > A_HI) begin
      ang_sat = wawm_pkg::ANGLE_W'(A_HI);
    end else if (ang_full < A_LO) begin
      ang_sat = wawm_pkg::ANGLE_W'(A_LO);
    end else begin
      ang_sat = wawm_pkg::ANGLE_W'(ang_full);
    end
  end

  always_comb begin
    mag_f  = $signed(FW'(mag));
    wrap_f = $signed(FW'({mag, 1'b1}));
    d0     = FW'(ang_r) - FW'(prev_r);
    d1     = (d0 > mag_f) ? d0 - wrap_f : d0;
    d2     = (d1 < -mag_f) ? d1 + wrap_f : d1;
    if (d2 > F_HI) begin
      chg_sat = wawm_pkg::ANGLE_W'(F_HI);
    end else if (d2 < F_LO) begin
      chg_sat = wawm_pkg::ANGLE_W'(F_LO);
    end else begin
      chg_sat = wawm_pkg::ANGLE_W'(d2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '0;
      hi_r   <= wawm_pkg::WINDOW_HIGH_RST;
      span_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wawm_pkg::CFG_WINDOW_LOW:  lo_r   <= cfg_data[wawm_pkg::MARK_W-1:0];
        wawm_pkg::CFG_WINDOW_HIGH: hi_r   <= cfg_data[wawm_pkg::MARK_W-1:0];
        wawm_pkg::CFG_OUT_SPAN:    span_r <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_r <= in_reading;
    end
    if (cmd.calc) begin
      pass_r  <= pass;
      empty_r <= len_zero;
      qneg_r  <= dist_adj[DW-1] ^ len[DW-1];
      den_r   <= len_mag;
      q_r     <= prod;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (cmd.step) begin
      rem_r <= ge ? trial[DENW-1:0] : shifted[DENW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.angle) begin
      ang_r <= ang_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (pass_r) begin
          prev_r <= $signed({{(wawm_pkg::ANGLE_W - wawm_pkg::READING_W){1'b0}}, rd_r});
        end else if (empty_r) begin
          last_r <= '0;
        end else begin
          prev_r <= ang_r;
          last_r <= chg_sat;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (pass_r) begin
        out_angle_r  <= $signed({{(wawm_pkg::ANGLE_W - wawm_pkg::READING_W){1'b0}}, rd_r});
        out_change_r <= last_r;
        out_empty_r  <= 1'b0;
      end else if (empty_r) begin
        out_angle_r  <= prev_r;
        out_change_r <= '0;
        out_empty_r  <= 1'b1;
      end else begin
        out_angle_r  <= ang_r;
        out_change_r <= chg_sat;
        out_empty_r  <= 1'b0;
      end
    end
  end

  assign status.bypass   = pass || len_zero;
  assign status.div_last = (cnt_r == LAST_CNT);
  assign status.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_angle        = out_angle_r;
  assign out_change       = out_change_r;
  assign out_window_empty = out_empty_r;

endmodule

### hdl/wrapped_window_angle_mapper.sv
// Top level of the wrapped window angle mapper: controller plus datapath.
// A mapped request is loaded in IDLE, then passes CALC, the DIV steps of the one-bit-per-cycle
// restoring divider fed with the NW-bit product (NW is 25 at the default range), then ANGLE
// and FIN, which writes the result register; passthrough and empty-window requests skip to FIN.
// No new request is accepted until FIN is left, and FIN waits while the output is stalled.
// Synchronous active-low reset restores register defaults, clears history and out_valid.
module wrapped_window_angle_mapper #(
  parameter int READING_RANGE = wawm_pkg::READING_RANGE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wawm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wawm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wawm_pkg::READING_W-1:0]      in_reading,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wawm_pkg::ANGLE_W-1:0] out_angle,
  output logic signed [wawm_pkg::ANGLE_W-1:0] out_change,
  output logic                                out_window_empty
);

  wawm_pkg::cmd_t    cmd;
  wawm_pkg::status_t status;

  wawm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wawm_dp #(
    .READING_RANGE (READING_RANGE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_reading       (in_reading),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_angle        (out_angle),
    .out_change       (out_change),
    .out_window_empty (out_window_empty),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
